[rtl/tct_pkg.sv]
// Package of the three-channel interval timer: widths, beat types, codes and
// byte helper functions. Depends on nothing.
`default_nettype none

package tct_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int NUM_COUNTERS = 3;
    localparam int NUM_RELOAD = 2;

    typedef logic [COUNT_WIDTH-1:0] count_t;

    localparam logic [2:0] KIND_WRITE = 3'd0;
    localparam logic [2:0] KIND_READ  = 3'd1;
    localparam logic [2:0] KIND_TICK0 = 3'd2;
    localparam logic [2:0] KIND_TICK1 = 3'd3;
    localparam logic [2:0] KIND_GATE  = 3'd4;

    localparam logic [1:0] CTRL_ADDR = 2'd3;
    localparam logic [1:0] SEL_NONE  = 2'd3;

    localparam logic [1:0] AM_ILLEGAL = 2'd0;
    localparam logic [1:0] AM_MSB     = 2'd1;
    localparam logic [1:0] AM_LSB     = 2'd2;
    localparam logic [1:0] AM_WORD    = 2'd3;

    localparam logic [7:0] RDATA_INVALID = 8'hff;

    localparam count_t COUNT_ONE = COUNT_WIDTH'(1);

    typedef struct packed {
        logic [2:0] kind;
        logic [1:0] addr;
        logic [7:0] wdata;
    } item_t;

    typedef struct packed {
        logic [7:0] rdata;
        logic       out0;
        logic       out1;
        logic       irq;
    } result_t;

    function automatic logic [7:0] count_hi(input count_t c);
        logic [15:0] w;
        w = 16'(c);
        return w[15:8];
    endfunction

    function automatic logic [7:0] count_lo(input count_t c);
        logic [15:0] w;
        w = 16'(c);
        return w[7:0];
    endfunction

    function automatic count_t from_bytes(input logic [7:0] hi, input logic [7:0] lo);
        logic [15:0] w;
        w = {hi, lo};
        return w[COUNT_WIDTH-1:0];
    endfunction

endpackage

`default_nettype wire

[rtl/tct_if.sv]
// Valid/ready channel interfaces for the timer's input and result beats.
// Depends on tct_pkg.
`default_nettype none

interface tct_in_if;
    import tct_pkg::*;

    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [1:0] addr;
    logic [7:0] wdata;

    modport source (output valid, output kind, output addr, output wdata, input ready);
    modport sink (input valid, input kind, input addr, input wdata, output ready);
endinterface

interface tct_out_if;
    import tct_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] rdata;
    logic       out0;
    logic       out1;
    logic       irq;

    modport source (output valid, output rdata, output out0, output out1, output irq,
                    input ready);
    modport sink (input valid, input rdata, input out0, input out1, input irq,
                  output ready);
endinterface

`default_nettype wire

[rtl/tct_in_stage.sv]
// Input register of the timer: holds one accepted beat for the core.
// Depends on tct_pkg.
`default_nettype none

module tct_in_stage
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire tct_pkg::item_t in_item,
    output logic               item_valid,
    input  wire logic          core_ready,
    output tct_pkg::item_t     item
);
    import tct_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_ready = !valid_reg || core_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (core_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

[rtl/tct_core.sv]
// Counter state of the timer, the single-pass update for one beat and the
// result register. Depends on tct_pkg.
`default_nettype none

module tct_core
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           item_valid,
    input  wire tct_pkg::item_t item,
    output logic                core_ready,
    output logic                res_valid,
    input  wire logic           res_ready,
    output tct_pkg::result_t    res
);
    import tct_pkg::*;

    count_t     cnt_reg    [NUM_COUNTERS];
    count_t     cnt_next   [NUM_COUNTERS];
    count_t     reload_reg [NUM_RELOAD];
    count_t     reload_next[NUM_RELOAD];
    logic [1:0] mode_reg   [NUM_COUNTERS];
    logic [1:0] mode_next  [NUM_COUNTERS];
    logic       msb_reg    [NUM_COUNTERS];
    logic       msb_next   [NUM_COUNTERS];
    count_t     latch_reg  [NUM_COUNTERS];
    count_t     latch_next [NUM_COUNTERS];
    logic       gate_reg;
    logic       gate_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    result_t    res_reg;
    result_t    res_next;
    logic       take;

    assign core_ready = !out_valid_reg || res_ready;
    assign take       = item_valid && core_ready;

    always_comb
    begin
        logic [1:0] sel;
        logic [1:0] rw;
        count_t     load_val;
        logic       load_en;
        count_t     dec2;

        sel      = item.wdata[7:6];
        rw       = item.wdata[5:4];
        load_val = '0;
        load_en  = 1'b0;
        dec2     = cnt_reg[2] - COUNT_ONE;

        cnt_next    = cnt_reg;
        reload_next = reload_reg;
        mode_next   = mode_reg;
        msb_next    = msb_reg;
        latch_next  = latch_reg;
        gate_next   = gate_reg;
        res_next.rdata = 8'h00;
        res_next.irq   = 1'b0;

        if (take)
        begin
            case (item.kind)
                KIND_WRITE:
                begin
                    if (item.addr == CTRL_ADDR)
                    begin
                        for (int i = 0; i < NUM_COUNTERS; i++)
                        begin
                            if (sel != SEL_NONE && sel == 2'(i))
                            begin
                                if (rw != AM_ILLEGAL)
                                begin
                                    mode_next[i] = rw;
                                end
                                msb_next[i]   = 1'b0;
                                latch_next[i] = cnt_reg[i];
                            end
                        end
                    end
                    else
                    begin
                        for (int i = 0; i < NUM_COUNTERS; i++)
                        begin
                            if (item.addr == 2'(i))
                            begin
                                load_en = 1'b0;
                                case (mode_reg[i])
                                    AM_MSB:
                                    begin
                                        load_val = from_bytes(item.wdata, 8'h00);
                                        load_en  = 1'b1;
                                    end
                                    AM_LSB:
                                    begin
                                        load_val = from_bytes(8'h00, item.wdata);
                                        load_en  = 1'b1;
                                    end
                                    AM_WORD:
                                    begin
                                        if (!msb_reg[i])
                                        begin
                                            latch_next[i] = from_bytes(8'h00, item.wdata);
                                            msb_next[i]   = 1'b1;
                                        end
                                        else
                                        begin
                                            msb_next[i] = 1'b0;
                                            load_val = from_bytes(item.wdata,
                                                                  count_lo(latch_reg[i]));
                                            load_en  = 1'b1;
                                        end
                                    end
                                    default:
                                    begin
                                        load_en = 1'b0;
                                    end
                                endcase
                                if (load_en)
                                begin
                                    cnt_next[i] = load_val;
                                    if (i < NUM_RELOAD)
                                    begin
                                        reload_next[i] = load_val;
                                    end
                                end
                            end
                        end
                    end
                end
                KIND_READ:
                begin
                    res_next.rdata = RDATA_INVALID;
                    for (int i = 0; i < NUM_COUNTERS; i++)
                    begin
                        if (item.addr == 2'(i))
                        begin
                            case (mode_reg[i])
                                AM_MSB:
                                begin
                                    res_next.rdata = count_hi(cnt_reg[i]);
                                end
                                AM_LSB:
                                begin
                                    res_next.rdata = count_lo(cnt_reg[i]);
                                end
                                AM_WORD:
                                begin
                                    if (!msb_reg[i])
                                    begin
                                        latch_next[i]  = cnt_reg[i];
                                        msb_next[i]    = 1'b1;
                                        res_next.rdata = count_lo(cnt_reg[i]);
                                    end
                                    else
                                    begin
                                        msb_next[i]    = 1'b0;
                                        res_next.rdata = count_hi(latch_reg[i]);
                                    end
                                end
                                default:
                                begin
                                    res_next.rdata = RDATA_INVALID;
                                end
                            endcase
                        end
                    end
                end
                KIND_TICK0:
                begin
                    if (gate_reg)
                    begin
                        if (cnt_reg[0] == COUNT_ONE)
                        begin
                            cnt_next[0] = reload_reg[0];
                        end
                        else
                        begin
                            cnt_next[0] = cnt_reg[0] - COUNT_ONE;
                        end
                    end
                end
                KIND_TICK1:
                begin
                    if (cnt_reg[1] == COUNT_ONE)
                    begin
                        cnt_next[1]  = reload_reg[1];
                        cnt_next[2]  = dec2;
                        res_next.irq = (dec2 == '0);
                    end
                    else
                    begin
                        cnt_next[1] = cnt_reg[1] - COUNT_ONE;
                    end
                end
                KIND_GATE:
                begin
                    gate_next = item.wdata[0];
                end
                default:
                begin
                    gate_next = gate_reg;
                end
            endcase
        end

        res_next.out0 = (cnt_next[0] != COUNT_ONE);
        res_next.out1 = (cnt_next[1] != COUNT_ONE);
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COUNTERS; i++)
            begin
                cnt_reg[i]   <= '0;
                mode_reg[i]  <= AM_ILLEGAL;
                msb_reg[i]   <= 1'b0;
                latch_reg[i] <= '0;
            end
            for (int i = 0; i < NUM_RELOAD; i++)
            begin
                reload_reg[i] <= '0;
            end
            gate_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            mode_reg      <= mode_next;
            msb_reg       <= msb_next;
            latch_reg     <= latch_next;
            reload_reg    <= reload_next;
            gate_reg      <= gate_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = res_reg;

    // A tick of counter 0 with its gate off must leave the count alone.
    a_gate_hold: assert property (@(posedge clk) disable iff (!rst_n)
        take && item.kind == KIND_TICK0 && !gate_reg |=> $stable(cnt_reg[0]))
        else $error("counter 0 moved with gate off");

    // A pending irq beat means counter 2 sits at zero until that beat leaves.
    a_irq_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.irq |-> cnt_reg[2] == '0)
        else $error("irq without counter 2 at zero");

    // Once an access mode is legal it never returns to the illegal code.
    a_mode0_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg[0] != AM_ILLEGAL |=> mode_reg[0] != AM_ILLEGAL)
        else $error("counter 0 access mode cleared");

    a_mode2_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg[2] != AM_ILLEGAL |=> mode_reg[2] != AM_ILLEGAL)
        else $error("counter 2 access mode cleared");

endmodule

`default_nettype wire

[rtl/three_channel_interval_timer.sv]
// Three-channel interval timer: a beat passes the input register, then the
// result register. Throughput is one beat per cycle while results are taken;
// the counter state is updated in the same cycle the result is formed.
// Reset (rst_n low, asynchronous) clears all counts, reload values, access
// modes, byte flip-flops, latches and the gate; no clearing pass is needed.
// Depends on tct_pkg, tct_if, tct_in_stage and tct_core.
`default_nettype none

module three_channel_interval_timer
(
    input wire logic clk,
    input wire logic rst_n,
    tct_in_if.sink   in_ch,
    tct_out_if.source out_ch
);
    import tct_pkg::*;

    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    core_ready;
    result_t res;

    assign in_item.kind  = in_ch.kind;
    assign in_item.addr  = in_ch.addr;
    assign in_item.wdata = in_ch.wdata;

    tct_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_ready   (in_ch.ready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .core_ready (core_ready),
        .item       (item)
    );

    tct_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .core_ready (core_ready),
        .res_valid  (out_ch.valid),
        .res_ready  (out_ch.ready),
        .res        (res)
    );

    assign out_ch.rdata = res.rdata;
    assign out_ch.out0  = res.out0;
    assign out_ch.out1  = res.out1;
    assign out_ch.irq   = res.irq;

endmodule

`default_nettype wire

[test/three_channel_interval_timer_tb.sv]
// Self-checking testbench for the three-channel interval timer: directed and random beats
// checked against a predictor of the counters kept in a small scoreboard class.
// Depends on tct_pkg, tct_if and the three_channel_interval_timer RTL.
`timescale 1ns / 100ps

import tct_pkg::*;

class timer_scoreboard;
    count_t      live_count[NUM_COUNTERS];
    count_t      reload_count[NUM_RELOAD];
    logic [1:0]  byte_mode[NUM_COUNTERS];
    bit          second_byte[NUM_COUNTERS];
    count_t      held_count[NUM_COUNTERS];
    bit          gate0;
    result_t     pending_results[$];
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned irq_count;
    int unsigned reloads;

    function new();
        foreach (live_count[i])
        begin
            live_count[i] = '0;
            byte_mode[i] = AM_ILLEGAL;
            second_byte[i] = 1'b0;
            held_count[i] = '0;
        end
        foreach (reload_count[i])
        begin
            reload_count[i] = '0;
        end
        gate0 = 1'b0;
        mismatches = 0;
        results_seen = 0;
        irq_count = 0;
        reloads = 0;
    endfunction

    function void load_counter(int c, count_t v);
        if (c < NUM_RELOAD)
        begin
            reload_count[c] = v;
        end
        live_count[c] = v;
    endfunction

    function bit rate_step(int c);
        if (live_count[c] == COUNT_ONE)
        begin
            live_count[c] = reload_count[c];
            reloads++;
            return 1'b1;
        end
        live_count[c] = live_count[c] - 1'b1;
        return 1'b0;
    endfunction

    function result_t step_timer(item_t beat);
        result_t     r;
        logic [1:0]  sel;
        logic [1:0]  rw;
        logic [15:0] wide;
        int          a;
        r = '0;
        a = beat.addr;
        case (beat.kind)
            KIND_WRITE:
            begin
                if (beat.addr == CTRL_ADDR)
                begin
                    sel = beat.wdata[7:6];
                    rw = beat.wdata[5:4];
                    if (sel != SEL_NONE)
                    begin
                        if (rw != AM_ILLEGAL)
                        begin
                            byte_mode[sel] = rw;
                        end
                        second_byte[sel] = 1'b0;
                        held_count[sel] = live_count[sel];
                    end
                end
                else
                begin
                    case (byte_mode[a])
                        AM_MSB: load_counter(a, count_t'({beat.wdata, 8'h00}));
                        AM_LSB: load_counter(a, count_t'({8'h00, beat.wdata}));
                        AM_WORD:
                        begin
                            if (!second_byte[a])
                            begin
                                held_count[a] = count_t'(beat.wdata);
                                second_byte[a] = 1'b1;
                            end
                            else
                            begin
                                second_byte[a] = 1'b0;
                                load_counter(a, count_t'({beat.wdata, held_count[a][7:0]}));
                            end
                        end
                        default: ;
                    endcase
                end
            end
            KIND_READ:
            begin
                if (beat.addr == CTRL_ADDR)
                begin
                    r.rdata = RDATA_INVALID;
                end
                else
                begin
                    wide = 16'(live_count[a]);
                    case (byte_mode[a])
                        AM_MSB: r.rdata = wide[15:8];
                        AM_LSB: r.rdata = wide[7:0];
                        AM_WORD:
                        begin
                            if (!second_byte[a])
                            begin
                                held_count[a] = live_count[a];
                                second_byte[a] = 1'b1;
                                r.rdata = wide[7:0];
                            end
                            else
                            begin
                                second_byte[a] = 1'b0;
                                wide = 16'(held_count[a]);
                                r.rdata = wide[15:8];
                            end
                        end
                        default: r.rdata = RDATA_INVALID;
                    endcase
                end
            end
            KIND_TICK0:
            begin
                if (gate0)
                begin
                    void'(rate_step(0));
                end
            end
            KIND_TICK1:
            begin
                if (rate_step(1))
                begin
                    live_count[2] = live_count[2] - 1'b1;
                    if (live_count[2] == '0)
                    begin
                        r.irq = 1'b1;
                        irq_count++;
                    end
                end
            end
            KIND_GATE: gate0 = beat.wdata[0];
            default: ;
        endcase
        r.out0 = (live_count[0] != COUNT_ONE);
        r.out1 = (live_count[1] != COUNT_ONE);
        return r;
    endfunction

    function void note_input(item_t beat);
        pending_results.push_back(step_timer(beat));
    endfunction

    function void check_result(result_t got);
        result_t want;
        results_seen++;
        if (pending_results.size() == 0)
        begin
            $error("unexpected result beat: rdata %0d out0 %0d out1 %0d irq %0d",
                   got.rdata, got.out0, got.out1, got.irq);
            mismatches++;
            return;
        end
        want = pending_results.pop_front();
        if (got.rdata !== want.rdata)
        begin
            $error("rdata mismatch: expected %0d, actual %0d", want.rdata, got.rdata);
            mismatches++;
        end
        if (got.out0 !== want.out0)
        begin
            $error("out0 mismatch: expected %0d, actual %0d", want.out0, got.out0);
            mismatches++;
        end
        if (got.out1 !== want.out1)
        begin
            $error("out1 mismatch: expected %0d, actual %0d", want.out1, got.out1);
            mismatches++;
        end
        if (got.irq !== want.irq)
        begin
            $error("irq mismatch: expected %0d, actual %0d", want.irq, got.irq);
            mismatches++;
        end
    endfunction
endclass

module three_channel_interval_timer_tb;
    localparam int RANDOM_BEATS = 1050;
    localparam int WATCHDOG_LIMIT = 2000;

    logic clk;
    logic rst_n;
    bit   steady_phase;
    int   beats_sent;
    int   live_beats;
    int   idle_cycles;

    timer_scoreboard model = new();

    tct_in_if  in_ch();
    tct_out_if out_ch();

    three_channel_interval_timer uut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic send(input logic [2:0] kind, input logic [1:0] addr, input logic [7:0] wdata);
        item_t beat;
        beat.kind = kind;
        beat.addr = addr;
        beat.wdata = wdata;
        if (!steady_phase)
        begin
            while ($urandom_range(99) < 38)
            begin
                in_ch.valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_ch.valid <= 1'b1;
        in_ch.kind <= kind;
        in_ch.addr <= addr;
        in_ch.wdata <= wdata;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        model.note_input(beat);
        beats_sent++;
        if (kind <= KIND_GATE)
        begin
            live_beats++;
        end
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (model.pending_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic program_counter();
        logic [1:0]  sel;
        logic [1:0]  rw;
        logic [15:0] value;
        sel = 2'($urandom_range(2));
        rw = 2'($urandom_range(1, 3));
        send(KIND_WRITE, CTRL_ADDR, {sel, rw, 4'($urandom_range(15))});
        if ($urandom_range(3) == 0)
        begin
            value = 16'($urandom_range(65535));
        end
        else
        begin
            value = 16'($urandom_range(0, 12));
        end
        case (rw)
            AM_MSB: send(KIND_WRITE, sel, value[15:8]);
            AM_LSB: send(KIND_WRITE, sel, value[7:0]);
            default:
            begin
                send(KIND_WRITE, sel, value[7:0]);
                if ($urandom_range(9) != 0)
                begin
                    send(KIND_WRITE, sel, value[15:8]);
                end
            end
        endcase
    endtask

    task automatic tick_burst();
        int n;
        n = $urandom_range(1, 16);
        repeat (n)
        begin
            send(($urandom_range(2) == 0) ? KIND_TICK0 : KIND_TICK1,
                 2'($urandom_range(3)), 8'($urandom_range(255)));
        end
    endtask

    task automatic read_burst();
        logic [1:0] target;
        int         n;
        target = 2'($urandom_range(3));
        if ($urandom_range(99) < 40)
        begin
            send(KIND_WRITE, CTRL_ADDR, {target, AM_ILLEGAL, 4'($urandom_range(15))});
        end
        n = $urandom_range(1, 3);
        repeat (n)
        begin
            send(KIND_READ, target, 8'($urandom_range(255)));
        end
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                model.check_result('{rdata: out_ch.rdata, out0: out_ch.out0,
                                     out1: out_ch.out1, irq: out_ch.irq});
            end
            out_ch.ready <= steady_phase || ($urandom_range(99) >= 38);
        end
    end

    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        int target;
        int pick;
        bit mid_drained;
        rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.kind <= KIND_WRITE;
        in_ch.addr <= '0;
        in_ch.wdata <= '0;
        out_ch.ready <= 1'b0;
        steady_phase = 1'b0;
        beats_sent = 0;
        live_beats = 0;
        mid_drained = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: illegal mode, a control read, counter select three, the
        // rate generators reloading, counter 2 wrapping and firing irq,
        // latch then two-byte read, gate off, unused kind, shared flip-flop.
        send(KIND_READ, 2'd0, 8'h00);
        send(KIND_WRITE, 2'd0, 8'hff);
        send(KIND_READ, CTRL_ADDR, 8'hff);
        send(KIND_WRITE, CTRL_ADDR, 8'hf0);
        send(KIND_WRITE, CTRL_ADDR, 8'h30);
        send(KIND_WRITE, 2'd0, 8'h03);
        send(KIND_WRITE, 2'd0, 8'h00);
        send(KIND_GATE, 2'd0, 8'h01);
        repeat (3) send(KIND_TICK0, 2'd0, 8'h00);
        send(KIND_WRITE, CTRL_ADDR, 8'h60);
        send(KIND_WRITE, 2'd1, 8'h02);
        send(KIND_WRITE, CTRL_ADDR, 8'h90);
        send(KIND_WRITE, 2'd2, 8'h00);
        repeat (2) send(KIND_TICK1, 2'd3, 8'hff);
        send(KIND_WRITE, CTRL_ADDR, 8'ha0);
        send(KIND_WRITE, 2'd2, 8'h01);
        repeat (2) send(KIND_TICK1, 2'd1, 8'h00);
        send(KIND_WRITE, CTRL_ADDR, 8'h00);
        send(KIND_TICK0, 2'd0, 8'h00);
        repeat (2) send(KIND_READ, 2'd0, 8'h00);
        send(KIND_GATE, 2'd3, 8'hfe);
        send(KIND_TICK0, 2'd2, 8'h55);
        send(3'd7, 2'd3, 8'hff);
        send(KIND_WRITE, 2'd0, 8'hff);
        send(KIND_READ, 2'd0, 8'h00);
        drain();

        target = live_beats + RANDOM_BEATS;
        while (live_beats < target)
        begin
            if (!mid_drained && live_beats >= target - RANDOM_BEATS + 300)
            begin
                drain();
                mid_drained = 1'b1;
            end
            steady_phase = (live_beats >= target - RANDOM_BEATS + 450) &&
                           (live_beats < target - RANDOM_BEATS + 650);
            pick = $urandom_range(99);
            if (pick < 22)
            begin
                program_counter();
            end
            else if (pick < 62)
            begin
                tick_burst();
            end
            else if (pick < 80)
            begin
                read_burst();
            end
            else if (pick < 88)
            begin
                send(KIND_GATE, 2'($urandom_range(3)),
                     {7'($urandom_range(127)), 1'($urandom_range(3) != 0)});
            end
            else
            begin
                send(3'($urandom_range(7)), 2'($urandom_range(3)), 8'($urandom_range(255)));
            end
        end
        steady_phase = 1'b0;
        in_ch.valid <= 1'b0;
        while (model.pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);

        $display("Run covered %0d input beats and %0d checked results, %0d mismatches.",
                 beats_sent, model.results_seen, model.mismatches);
        $display("Counters reloaded %0d times and counter 2 raised irq %0d times.",
                 model.reloads, model.irq_count);
        if (model.mismatches == 0 && model.pending_results.size() == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

[sim.f]
rtl/tct_pkg.sv
rtl/tct_if.sv
rtl/tct_in_stage.sv
rtl/tct_core.sv
rtl/three_channel_interval_timer.sv
test/three_channel_interval_timer_tb.sv
